// ===== hw/rtl/grct_pkg.sv =====
`default_nettype none
package grct_pkg;

   // internal time and coordinate width, Q16.16 with headroom
   localparam int TW = 64;
   // step counter width for one bit per cycle over TW bits
   localparam int CW = 6;

   typedef logic signed [TW-1:0] time_type;

   // crossing time for an axis the ray never crosses
   localparam time_type T_HUGE = 64'sh1000_0000_0000_0000;

   // arithmetic unit operations
   localparam logic [1:0] OP_MUL  = 2'd0;   // signed product
   localparam logic [1:0] OP_DIVT = 2'd1;   // signed quotient, toward zero
   localparam logic [1:0] OP_DIVF = 2'd2;   // signed quotient, toward minus infinity

   typedef struct packed {
      logic       go;
      logic [1:0] op;
      time_type   a;
      time_type   b;
   } mdu_req_type;

   typedef struct packed {
      logic     done;
      time_type res;
   } mdu_rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/grct_mdu.sv =====
`default_nettype none
module grct_mdu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire grct_pkg::mdu_req_type req,
   output grct_pkg::mdu_rsp_type      rsp
);

   localparam int TW = grct_pkg::TW;
   localparam int CW = grct_pkg::CW;

   logic                busy_ff, busy_in;
   logic                fin_ff, fin_in;
   logic                done_ff, done_in;
   logic                mul_ff, mul_in;
   logic                flr_ff, flr_in;
   logic                neg_ff, neg_in;
   logic [TW-1:0]       acc_ff, acc_in;
   logic [TW-1:0]       aux_ff, aux_in;
   logic [TW-1:0]       qm_ff, qm_in;
   logic [TW:0]         rem_ff, rem_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   grct_pkg::time_type  res_ff, res_in;

   logic [TW-1:0] ua, ub, a_mag, b_mag, src;
   logic [TW:0]   shifted, diff;

   always_comb begin
      ua      = req.a;
      ub      = req.b;
      a_mag   = ua[TW-1] ? (~ua + TW'(1)) : ua;
      b_mag   = ub[TW-1] ? (~ub + TW'(1)) : ub;
      shifted = {rem_ff[TW-1:0], qm_ff[TW-1]};
      diff    = shifted - {1'b0, aux_ff};
      src     = mul_ff ? acc_ff : qm_ff;

      busy_in = busy_ff;
      fin_in  = fin_ff;
      done_in = 1'b0;
      mul_in  = mul_ff;
      flr_in  = flr_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      aux_in  = aux_ff;
      qm_in   = qm_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;

      if (req.go && !busy_ff) begin
         busy_in = 1'b1;
         fin_in  = 1'b0;
         mul_in  = (req.op == grct_pkg::OP_MUL);
         flr_in  = (req.op == grct_pkg::OP_DIVF);
         neg_in  = ua[TW-1] ^ ub[TW-1];
         aux_in  = (req.op == grct_pkg::OP_MUL) ? a_mag : b_mag;
         qm_in   = (req.op == grct_pkg::OP_MUL) ? b_mag : a_mag;
         acc_in  = '0;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff && fin_ff) begin
         // apply sign, and round the quotient down when asked
         busy_in = 1'b0;
         fin_in  = 1'b0;
         done_in = 1'b1;
         if (!mul_ff && flr_ff && neg_ff && (rem_ff != '0)) begin
            res_in = ~src;
         end else if (neg_ff) begin
            res_in = ~src + TW'(1);
         end else begin
            res_in = src;
         end
      end else if (busy_ff) begin
         if (mul_ff) begin
            // shift-add, stop once the multiplier runs out of ones
            if (qm_ff == '0) begin
               fin_in = 1'b1;
            end else begin
               if (qm_ff[0]) begin
                  acc_in = acc_ff + aux_ff;
               end
               aux_in = {aux_ff[TW-2:0], 1'b0};
               qm_in  = {1'b0, qm_ff[TW-1:1]};
            end
         end else begin
            // restoring divide, one quotient bit a cycle
            if (diff[TW]) begin
               rem_in = shifted;
               qm_in  = {qm_ff[TW-2:0], 1'b0};
            end else begin
               rem_in = diff;
               qm_in  = {qm_ff[TW-2:0], 1'b1};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(TW - 1)) begin
               fin_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      mul_ff <= mul_in;
      flr_ff <= flr_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      qm_ff  <= qm_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/grid_ray_cell_traversal.sv =====
`default_nettype none
// Ray walk through a uniform grid (3D DDA). Pulse start while busy is low to hand
// over one ray (origin and direction, signed Q16.16); busy stays high until the
// walk ends. Results come out on rsp_* for exactly one cycle each, marked by
// rsp_strobe, and cannot be held off: the receiver must take every strobe. A
// ray that misses the box gives one result with rsp_missed and rsp_last set;
// otherwise every visited cell comes out in order, one per cycle, with the time
// the ray leaves it, and the final one carries rsp_last. Setup runs on a single
// shared 64-bit multiply/divide unit, one bit per cycle. An axis with a nonzero
// direction needs four divides and three multiplies; an axis with a zero
// direction needs one multiply and one divide. A range check follows the slab
// divides of all three axes and sends a ray that misses to the miss result
// before the rest of setup; then the cells are emitted (at most
// 3*MAX_CELLS_PER_AXIS-2). Box and grid registers are to be written through the
// csr_* port only while busy is low and no result is pending; the block itself
// does not enforce this.
module grid_ray_cell_traversal #(
   parameter int MAX_CELLS_PER_AXIS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic signed [31:0] req_origin_x,
   input  wire logic signed [31:0] req_origin_y,
   input  wire logic signed [31:0] req_origin_z,
   input  wire logic signed [31:0] req_dir_x,
   input  wire logic signed [31:0] req_dir_y,
   input  wire logic signed [31:0] req_dir_z,
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata,
   output      logic               rsp_strobe,
   output      logic [3:0]         rsp_cell_x,
   output      logic [3:0]         rsp_cell_y,
   output      logic [3:0]         rsp_cell_z,
   output      logic [11:0]        rsp_cell_index,
   output      logic signed [31:0] rsp_t_exit,
   output      logic               rsp_missed,
   output      logic               rsp_last
);

   localparam int TW         = grct_pkg::TW;
   localparam int WALK_LIMIT = 3 * MAX_CELLS_PER_AXIS - 2;
   localparam int WLW        = $clog2(WALK_LIMIT + 1);

   // register indexes
   localparam logic [2:0] CSR_MIN_X = 3'd0;
   localparam logic [2:0] CSR_MIN_Y = 3'd1;
   localparam logic [2:0] CSR_MIN_Z = 3'd2;
   localparam logic [2:0] CSR_MAX_X = 3'd3;
   localparam logic [2:0] CSR_MAX_Y = 3'd4;
   localparam logic [2:0] CSR_MAX_Z = 3'd5;
   localparam logic [2:0] CSR_DIMS  = 3'd6;

   // sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SLAB_LO  = 4'd1;
   localparam logic [3:0] ST_SLAB_HI  = 4'd2;
   localparam logic [3:0] ST_RANGE    = 4'd3;
   localparam logic [3:0] ST_POS      = 4'd4;
   localparam logic [3:0] ST_CELL_MUL = 4'd5;
   localparam logic [3:0] ST_CELL_DIV = 4'd6;
   localparam logic [3:0] ST_DT_DIV   = 4'd7;
   localparam logic [3:0] ST_NXT_MUL  = 4'd8;
   localparam logic [3:0] ST_WALK     = 4'd9;
   localparam logic [3:0] ST_MISS     = 4'd10;

   localparam grct_pkg::time_type SAT_HI = 64'sd2147483647;
   localparam grct_pkg::time_type SAT_LO = -64'sd2147483648;

   // configuration
   logic signed [31:0] box_lo_ff [3];
   logic signed [31:0] box_lo_in [3];
   logic signed [31:0] box_hi_ff [3];
   logic signed [31:0] box_hi_in [3];
   logic [11:0]        dims_ff, dims_in;

   // ray and walk state
   logic [3:0]         state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic               issued_ff, issued_in;
   logic [WLW-1:0]     cnt_ff, cnt_in;
   logic signed [31:0] org_ff [3];
   logic signed [31:0] org_in [3];
   logic signed [31:0] dir_ff [3];
   logic signed [31:0] dir_in [3];
   grct_pkg::time_type tmn_ff [3];
   grct_pkg::time_type tmn_in [3];
   grct_pkg::time_type tmx_ff [3];
   grct_pkg::time_type tmx_in [3];
   grct_pkg::time_type nxt_ff [3];
   grct_pkg::time_type nxt_in [3];
   grct_pkg::time_type dt_ff [3];
   grct_pkg::time_type dt_in [3];
   logic [3:0]         cell_ff [3];
   logic [3:0]         cell_in [3];
   grct_pkg::time_type tmp_ff, tmp_in;
   grct_pkg::time_type ts_ff, ts_in;

   // result registers
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [3:0]         rsp_cx_ff, rsp_cx_in;
   logic [3:0]         rsp_cy_ff, rsp_cy_in;
   logic [3:0]         rsp_cz_ff, rsp_cz_in;
   logic [11:0]        rsp_idx_ff, rsp_idx_in;
   logic signed [31:0] rsp_t_ff, rsp_t_in;
   logic               rsp_miss_ff, rsp_miss_in;
   logic               rsp_last_ff, rsp_last_in;

   grct_pkg::mdu_req_type mdu_req;
   grct_pkg::mdu_rsp_type mdu_rsp;

   // per-axis cell counts, clamped
   logic [4:0]         n_w [3];
   logic [9:0]         n01_w;
   logic               pre_miss;

   // values of the axis under work
   grct_pkg::time_type o_ax, d_ax, lo_ax, hi_ax, n_ax;
   logic [3:0]         c_ax;
   logic               dpos_ax;

   // walk selection
   logic [1:0]         sel;
   grct_pkg::time_type nxt_sel;
   logic [4:0]         n_sel;
   logic [3:0]         c_sel;
   logic               fin;
   logic [11:0]        idx_w;
   logic signed [31:0] t_sat;

   // slab range
   grct_pkg::time_type mx01, mn01, t0, t1;

   grct_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .req   (mdu_req),
      .rsp   (mdu_rsp)
   );

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         n_w[a] = {1'b0, dims_ff[4*a +: 4]} + 5'd1;
         if (n_w[a] > 5'(MAX_CELLS_PER_AXIS)) begin
            n_w[a] = 5'(MAX_CELLS_PER_AXIS);
         end
      end
      n01_w = 10'(n_w[0]) * 10'(n_w[1]);

      pre_miss = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (box_hi_ff[a] <= box_lo_ff[a]) begin
            pre_miss = 1'b1;
         end
         if ((dir_ff[a] == '0) &&
             ((org_ff[a] < box_lo_ff[a]) || (org_ff[a] > box_hi_ff[a]))) begin
            pre_miss = 1'b1;
         end
      end

      o_ax    = grct_pkg::time_type'(org_ff[axis_ff]);
      d_ax    = grct_pkg::time_type'(dir_ff[axis_ff]);
      lo_ax   = grct_pkg::time_type'(box_lo_ff[axis_ff]);
      hi_ax   = grct_pkg::time_type'(box_hi_ff[axis_ff]);
      n_ax    = grct_pkg::time_type'(n_w[axis_ff]);
      c_ax    = cell_ff[axis_ff];
      dpos_ax = !dir_ff[axis_ff][31];

      mx01 = (tmn_ff[0] > tmn_ff[1]) ? tmn_ff[0] : tmn_ff[1];
      t0   = (mx01 > tmn_ff[2]) ? mx01 : tmn_ff[2];
      mn01 = (tmx_ff[0] < tmx_ff[1]) ? tmx_ff[0] : tmx_ff[1];
      t1   = (mn01 < tmx_ff[2]) ? mn01 : tmx_ff[2];

      // x only when strictly earliest, then y when strictly before z
      priority if ((nxt_ff[0] < nxt_ff[1]) && (nxt_ff[0] < nxt_ff[2])) begin
         sel = 2'd0;
      end else if (nxt_ff[1] < nxt_ff[2]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
      nxt_sel = nxt_ff[sel];
      n_sel   = n_w[sel];
      c_sel   = cell_ff[sel];

      fin = (nxt_sel >= grct_pkg::T_HUGE) || (cnt_ff == WLW'(WALK_LIMIT - 1));
      if (!dir_ff[sel][31]) begin
         if ({1'b0, c_sel} == (n_sel - 5'd1)) begin
            fin = 1'b1;
         end
      end else if (c_sel == 4'd0) begin
         fin = 1'b1;
      end

      if (nxt_sel > SAT_HI) begin
         t_sat = 32'sh7FFF_FFFF;
      end else if (nxt_sel < SAT_LO) begin
         t_sat = 32'sh8000_0000;
      end else begin
         t_sat = nxt_sel[31:0];
      end

      idx_w = 12'(cell_ff[0]) + 12'(n_w[0]) * 12'(cell_ff[1])
            + 12'(n01_w) * 12'(cell_ff[2]);
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         box_lo_in[a] = box_lo_ff[a];
         box_hi_in[a] = box_hi_ff[a];
         org_in[a]    = org_ff[a];
         dir_in[a]    = dir_ff[a];
         tmn_in[a]    = tmn_ff[a];
         tmx_in[a]    = tmx_ff[a];
         nxt_in[a]    = nxt_ff[a];
         dt_in[a]     = dt_ff[a];
         cell_in[a]   = cell_ff[a];
      end
      dims_in   = dims_ff;
      state_in  = state_ff;
      axis_in   = axis_ff;
      issued_in = issued_ff;
      cnt_in    = cnt_ff;
      tmp_in    = tmp_ff;
      ts_in     = ts_ff;

      rsp_strobe_in = 1'b0;
      rsp_cx_in     = rsp_cx_ff;
      rsp_cy_in     = rsp_cy_ff;
      rsp_cz_in     = rsp_cz_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_t_in      = rsp_t_ff;
      rsp_miss_in   = rsp_miss_ff;
      rsp_last_in   = rsp_last_ff;

      mdu_req.go = 1'b0;
      mdu_req.op = grct_pkg::OP_MUL;
      mdu_req.a  = '0;
      mdu_req.b  = '0;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_X: box_lo_in[0] = csr_wdata;
            CSR_MIN_Y: box_lo_in[1] = csr_wdata;
            CSR_MIN_Z: box_lo_in[2] = csr_wdata;
            CSR_MAX_X: box_hi_in[0] = csr_wdata;
            CSR_MAX_Y: box_hi_in[1] = csr_wdata;
            CSR_MAX_Z: box_hi_in[2] = csr_wdata;
            CSR_DIMS:  dims_in      = csr_wdata[11:0];
            default:   ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               org_in[0] = req_origin_x;
               org_in[1] = req_origin_y;
               org_in[2] = req_origin_z;
               dir_in[0] = req_dir_x;
               dir_in[1] = req_dir_y;
               dir_in[2] = req_dir_z;
               axis_in   = 2'd0;
               issued_in = 1'b0;
               state_in  = ST_SLAB_LO;
            end
         end

         ST_SLAB_LO: begin
            if (d_ax == '0) begin
               // never crossed: unbounded slab
               tmn_in[axis_ff] = -grct_pkg::T_HUGE;
               tmx_in[axis_ff] = grct_pkg::T_HUGE;
               axis_in  = axis_ff + 2'd1;
               state_in = (axis_ff == 2'd2) ? ST_RANGE : ST_SLAB_LO;
            end else begin
               mdu_req.go = !issued_ff;
               mdu_req.op = grct_pkg::OP_DIVT;
               mdu_req.a  = (lo_ax - o_ax) <<< 16;
               mdu_req.b  = d_ax;
               issued_in  = 1'b1;
               if (mdu_rsp.done) begin
                  tmp_in    = mdu_rsp.res;
                  issued_in = 1'b0;
                  state_in  = ST_SLAB_HI;
               end
            end
         end

         ST_SLAB_HI: begin
            mdu_req.go = !issued_ff;
            mdu_req.op = grct_pkg::OP_DIVT;
            mdu_req.a  = (hi_ax - o_ax) <<< 16;
            mdu_req.b  = d_ax;
            issued_in  = 1'b1;
            if (mdu_rsp.done) begin
               tmn_in[axis_ff] = dpos_ax ? tmp_ff : mdu_rsp.res;
               tmx_in[axis_ff] = dpos_ax ? mdu_rsp.res : tmp_ff;
               issued_in = 1'b0;
               axis_in   = axis_ff + 2'd1;
               state_in  = (axis_ff == 2'd2) ? ST_RANGE : ST_SLAB_LO;
            end
         end

         ST_RANGE: begin
            axis_in = 2'd0;
            ts_in   = (t0 > 0) ? t0 : '0;
            if (pre_miss || (t0 > t1) || (t1 < 0)) begin
               state_in = ST_MISS;
            end else begin
               state_in = ST_POS;
            end
         end

         ST_POS: begin
            // entry point on this axis
            if (d_ax == '0) begin
               tmp_in   = o_ax;
               state_in = ST_CELL_MUL;
            end else begin
               mdu_req.go = !issued_ff;
               mdu_req.op = grct_pkg::OP_MUL;
               mdu_req.a  = ts_ff;
               mdu_req.b  = d_ax;
               issued_in  = 1'b1;
               if (mdu_rsp.done) begin
                  tmp_in    = o_ax + (mdu_rsp.res >>> 16);
                  issued_in = 1'b0;
                  state_in  = ST_CELL_MUL;
               end
            end
         end

         ST_CELL_MUL: begin
            mdu_req.go = !issued_ff;
            mdu_req.op = grct_pkg::OP_MUL;
            mdu_req.a  = tmp_ff - lo_ax;
            mdu_req.b  = n_ax;
            issued_in  = 1'b1;
            if (mdu_rsp.done) begin
               tmp_in    = mdu_rsp.res;
               issued_in = 1'b0;
               state_in  = ST_CELL_DIV;
            end
         end

         ST_CELL_DIV: begin
            mdu_req.go = !issued_ff;
            mdu_req.op = grct_pkg::OP_DIVF;
            mdu_req.a  = tmp_ff;
            mdu_req.b  = hi_ax - lo_ax;
            issued_in  = 1'b1;
            if (mdu_rsp.done) begin
               issued_in = 1'b0;
               // clamp into the grid
               if (mdu_rsp.res < 0) begin
                  cell_in[axis_ff] = 4'd0;
               end else if (mdu_rsp.res > (n_ax - 1)) begin
                  cell_in[axis_ff] = 4'(n_w[axis_ff] - 5'd1);
               end else begin
                  cell_in[axis_ff] = mdu_rsp.res[3:0];
               end
               if (d_ax == '0) begin
                  nxt_in[axis_ff] = grct_pkg::T_HUGE;
                  dt_in[axis_ff]  = '0;
                  axis_in  = axis_ff + 2'd1;
                  cnt_in   = '0;
                  state_in = (axis_ff == 2'd2) ? ST_WALK : ST_POS;
               end else begin
                  state_in = ST_DT_DIV;
               end
            end
         end

         ST_DT_DIV: begin
            mdu_req.go = !issued_ff;
            mdu_req.op = grct_pkg::OP_DIVT;
            mdu_req.a  = tmx_ff[axis_ff] - tmn_ff[axis_ff];
            mdu_req.b  = n_ax;
            issued_in  = 1'b1;
            if (mdu_rsp.done) begin
               dt_in[axis_ff] = mdu_rsp.res;
               issued_in = 1'b0;
               state_in  = ST_NXT_MUL;
            end
         end

         ST_NXT_MUL: begin
            // first boundary ahead of the start cell
            mdu_req.go = !issued_ff;
            mdu_req.op = grct_pkg::OP_MUL;
            mdu_req.a  = dt_ff[axis_ff];
            mdu_req.b  = dpos_ax ? grct_pkg::time_type'({1'b0, c_ax} + 5'd1)
                                 : grct_pkg::time_type'(n_w[axis_ff] - {1'b0, c_ax});
            issued_in  = 1'b1;
            if (mdu_rsp.done) begin
               nxt_in[axis_ff] = tmn_ff[axis_ff] + mdu_rsp.res;
               issued_in = 1'b0;
               axis_in   = axis_ff + 2'd1;
               cnt_in    = '0;
               state_in  = (axis_ff == 2'd2) ? ST_WALK : ST_POS;
            end
         end

         ST_WALK: begin
            rsp_strobe_in = 1'b1;
            rsp_cx_in     = cell_ff[0];
            rsp_cy_in     = cell_ff[1];
            rsp_cz_in     = cell_ff[2];
            rsp_idx_in    = idx_w;
            rsp_t_in      = t_sat;
            rsp_miss_in   = 1'b0;
            rsp_last_in   = fin;
            cnt_in        = cnt_ff + WLW'(1);
            if (fin) begin
               state_in = ST_IDLE;
            end else begin
               // advance along the axis hit first
               nxt_in[sel]  = nxt_sel + dt_ff[sel];
               cell_in[sel] = dir_ff[sel][31] ? (c_sel - 4'd1) : (c_sel + 4'd1);
            end
         end

         ST_MISS: begin
            rsp_strobe_in = 1'b1;
            rsp_cx_in     = '0;
            rsp_cy_in     = '0;
            rsp_cz_in     = '0;
            rsp_idx_in    = '0;
            rsp_t_in      = '0;
            rsp_miss_in   = 1'b1;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_lo_ff[a] <= '0;
            box_hi_ff[a] <= 32'sd65536;
         end
         dims_ff       <= '0;
         state_ff      <= ST_IDLE;
         issued_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         for (int a = 0; a < 3; a++) begin
            box_lo_ff[a] <= box_lo_in[a];
            box_hi_ff[a] <= box_hi_in[a];
         end
         dims_ff       <= dims_in;
         state_ff      <= state_in;
         issued_ff     <= issued_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      for (int a = 0; a < 3; a++) begin
         org_ff[a]  <= org_in[a];
         dir_ff[a]  <= dir_in[a];
         tmn_ff[a]  <= tmn_in[a];
         tmx_ff[a]  <= tmx_in[a];
         nxt_ff[a]  <= nxt_in[a];
         dt_ff[a]   <= dt_in[a];
         cell_ff[a] <= cell_in[a];
      end
      axis_ff     <= axis_in;
      cnt_ff      <= cnt_in;
      tmp_ff      <= tmp_in;
      ts_ff       <= ts_in;
      rsp_cx_ff   <= rsp_cx_in;
      rsp_cy_ff   <= rsp_cy_in;
      rsp_cz_ff   <= rsp_cz_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_t_ff    <= rsp_t_in;
      rsp_miss_ff <= rsp_miss_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cell_x     = rsp_cx_ff;
   assign rsp_cell_y     = rsp_cy_ff;
   assign rsp_cell_z     = rsp_cz_ff;
   assign rsp_cell_index = rsp_idx_ff;
   assign rsp_t_exit     = rsp_t_ff;
   assign rsp_missed     = rsp_miss_ff;
   assign rsp_last       = rsp_last_ff;

   // a walk emits on consecutive cycles until its last cell
   a_walk_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("walk result gap");

   // a miss is always a single, final result
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_missed |-> rsp_last && (rsp_cell_index == 12'd0))
      else $error("miss result malformed");

   // the arithmetic unit only answers while a ray is in setup
   a_mdu_in_setup: assert property (@(posedge clock) disable iff (reset)
      mdu_rsp.done |-> (state_ff != ST_IDLE) && (state_ff != ST_WALK)
                       && (state_ff != ST_MISS))
      else $error("arithmetic result outside setup");

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("request not taken");

endmodule
`default_nettype wire
